// ===== rtl/core/iol_pkg.sv =====
// shared types and constants for the indexed ordered list
package iol_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int CMD_W        = 4;
	localparam int ELEM_W       = 6;
	localparam int STAT_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 4'd0,
		CMD_INS_TAIL = 4'd1,
		CMD_INS_AT   = 4'd2,
		CMD_REPLACE  = 4'd3,
		CMD_READ     = 4'd4,
		CMD_CONTAINS = 4'd5,
		CMD_RM_MATCH = 4'd6,
		CMD_RM_HEAD  = 4'd7,
		CMD_RM_TAIL  = 4'd8,
		CMD_RM_AT    = 4'd9
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHUP_RD,
		S_SHUP_WR,
		S_PUT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_TAKE_RD,
		S_TAKE_WAIT,
		S_SHDN_RD,
		S_SHDN_WR,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/indexed_ordered_list.sv =====
// indexed ordered list: top level with sequencer and entry memory
//
// Keeps an ordered list of up to CAPACITY element codes. One command beat on
// the s_ side yields exactly one result beat on the m_ side.
// s_tdata fields: command, position, element. m_tdata fields: element_out,
// found, count, status.
// The entries sit in a memory with a write port and a registered read port;
// one sequencer walks it, moving an entry with a read and a write state or
// comparing one with a read and a compare state. Full or range errors,
// unused commands and a search of an empty list go straight to the result;
// replace and tail insert write the entry, read fetches the entry at the
// position, other inserts shift the entries from the position up first,
// removals fetch the entry then shift the later ones down, searches compare
// from the head and remove-match shifts the later ones down. s_tready is high
// only while the sequencer is idle, so one command is worked on at a time.
// The result sits in an output register; while the receiver stalls, the next
// command is still taken and worked on up to its result, which then waits.
// Reset empties the list and drops any pending result; the memory is not
// cleared, since only positions below the count are ever read.
module indexed_ordered_list #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// command [3:0], position, element, zero pad
	input  logic [((iol_pkg::CMD_W + $clog2(CAPACITY + 1) + iol_pkg::ELEM_W + 7) / 8) * 8 - 1:0]
		s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// element_out, found, count, status, zero pad
	output logic [((iol_pkg::ELEM_W + 1 + $clog2(CAPACITY + 1) + iol_pkg::STAT_W + 7) / 8) * 8 - 1:0]
		m_tdata
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EW     = iol_pkg::ELEM_W;
	localparam int OUT_W  = EW + 1 + CNT_W + iol_pkg::STAT_W;
	localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

	iol_pkg::state_t state_q, state_d;

	iol_pkg::cmd_t    cmd_q, cmd_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [EW-1:0]    code_q, code_d;
	logic [EW-1:0]    elem_q, elem_d;
	logic             found_q, found_d;
	iol_pkg::status_t status_q, status_d;

	logic              m_tvalid_q, m_tvalid_d;
	logic [OUT_PW-1:0] m_tdata_q, m_tdata_d;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [EW-1:0] wd;

	logic [CNT_W-1:0] in_pos;
	logic [EW-1:0]    in_elem;
	logic             full;
	logic [CNT_W-1:0] idx_inc, idx_dec, pos_inc;

	assign in_pos  = s_tdata[iol_pkg::CMD_W +: CNT_W];
	assign in_elem = s_tdata[iol_pkg::CMD_W + CNT_W +: EW];
	assign full    = (held_q == CNT_W'(CAPACITY));
	assign idx_inc = CNT_W'(idx_q + 1'b1);
	assign idx_dec = CNT_W'(idx_q - 1'b1);
	assign pos_inc = CNT_W'(pos_q + 1'b1);

	assign s_tready = (state_q == iol_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// entry memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= iol_pkg::S_IDLE;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			held_q     <= held_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		pos_q     <= pos_d;
		idx_q     <= idx_d;
		code_q    <= code_d;
		elem_q    <= elem_d;
		found_q   <= found_d;
		status_q  <= status_d;
		m_tdata_q <= m_tdata_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		pos_d      = pos_q;
		idx_d      = idx_q;
		held_d     = held_q;
		code_d     = code_q;
		elem_d     = elem_q;
		found_d    = found_q;
		status_d   = status_q;
		m_tvalid_d = m_tvalid_q;
		m_tdata_d  = m_tdata_q;
		we         = 1'b0;
		wa         = idx_q[AW-1:0];
		wd         = rd_q;
		ra         = idx_q[AW-1:0];

		if (m_tvalid_q && m_tready) begin
			m_tvalid_d = 1'b0;
		end

		case (state_q)
			iol_pkg::S_IDLE: begin
				if (s_tvalid) begin
					cmd_d    = iol_pkg::cmd_t'(s_tdata[iol_pkg::CMD_W-1:0]);
					pos_d    = in_pos;
					code_d   = in_elem;
					elem_d   = '0;
					found_d  = 1'b0;
					status_d = iol_pkg::ST_OK;
					idx_d    = held_q;
					state_d  = iol_pkg::S_DONE;
					case (iol_pkg::cmd_t'(s_tdata[iol_pkg::CMD_W-1:0]))
						iol_pkg::CMD_INS_HEAD: begin
							pos_d = '0;
							if (full) begin
								status_d = iol_pkg::ST_FULL;
							end else if (held_q == '0) begin
								state_d = iol_pkg::S_PUT;
							end else begin
								state_d = iol_pkg::S_SHUP_RD;
							end
						end
						iol_pkg::CMD_INS_TAIL: begin
							pos_d = held_q;
							if (full) begin
								status_d = iol_pkg::ST_FULL;
							end else begin
								state_d = iol_pkg::S_PUT;
							end
						end
						iol_pkg::CMD_INS_AT: begin
							if (in_pos > held_q) begin
								status_d = iol_pkg::ST_RANGE;
							end else if (full) begin
								status_d = iol_pkg::ST_FULL;
							end else if (in_pos == held_q) begin
								state_d = iol_pkg::S_PUT;
							end else begin
								state_d = iol_pkg::S_SHUP_RD;
							end
						end
						iol_pkg::CMD_REPLACE: begin
							if (in_pos >= held_q) begin
								status_d = iol_pkg::ST_RANGE;
							end else begin
								state_d = iol_pkg::S_PUT;
							end
						end
						iol_pkg::CMD_READ, iol_pkg::CMD_RM_AT: begin
							if (in_pos >= held_q) begin
								status_d = iol_pkg::ST_RANGE;
							end else begin
								state_d = iol_pkg::S_TAKE_RD;
							end
						end
						iol_pkg::CMD_CONTAINS, iol_pkg::CMD_RM_MATCH: begin
							idx_d = '0;
							if (held_q != '0) begin
								state_d = iol_pkg::S_SRCH_RD;
							end
						end
						iol_pkg::CMD_RM_HEAD: begin
							pos_d = '0;
							if (held_q == '0) begin
								status_d = iol_pkg::ST_RANGE;
							end else begin
								state_d = iol_pkg::S_TAKE_RD;
							end
						end
						iol_pkg::CMD_RM_TAIL: begin
							pos_d = CNT_W'(held_q - 1'b1);
							if (held_q == '0) begin
								status_d = iol_pkg::ST_RANGE;
							end else begin
								state_d = iol_pkg::S_TAKE_RD;
							end
						end
						default: begin
							state_d = iol_pkg::S_DONE;
						end
					endcase
				end
			end

			// move entry idx-1 up to idx
			iol_pkg::S_SHUP_RD: begin
				ra      = idx_dec[AW-1:0];
				state_d = iol_pkg::S_SHUP_WR;
			end
			iol_pkg::S_SHUP_WR: begin
				we    = 1'b1;
				wa    = idx_q[AW-1:0];
				wd    = rd_q;
				idx_d = idx_dec;
				if (idx_dec == pos_q) begin
					state_d = iol_pkg::S_PUT;
				end else begin
					state_d = iol_pkg::S_SHUP_RD;
				end
			end
			iol_pkg::S_PUT: begin
				we = 1'b1;
				wa = pos_q[AW-1:0];
				wd = code_q;
				if (cmd_q != iol_pkg::CMD_REPLACE) begin
					held_d = CNT_W'(held_q + 1'b1);
				end
				state_d = iol_pkg::S_DONE;
			end

			// linear search from the head
			iol_pkg::S_SRCH_RD: begin
				ra      = idx_q[AW-1:0];
				state_d = iol_pkg::S_SRCH_CMP;
			end
			iol_pkg::S_SRCH_CMP: begin
				if (rd_q == code_q) begin
					found_d = 1'b1;
					if (cmd_q == iol_pkg::CMD_RM_MATCH) begin
						elem_d = rd_q;
						pos_d  = idx_q;
						idx_d  = idx_inc;
						if (idx_inc >= held_q) begin
							held_d  = CNT_W'(held_q - 1'b1);
							state_d = iol_pkg::S_DONE;
						end else begin
							state_d = iol_pkg::S_SHDN_RD;
						end
					end else begin
						state_d = iol_pkg::S_DONE;
					end
				end else begin
					idx_d = idx_inc;
					if (idx_inc == held_q) begin
						state_d = iol_pkg::S_DONE;
					end else begin
						state_d = iol_pkg::S_SRCH_RD;
					end
				end
			end

			// fetch the entry at pos
			iol_pkg::S_TAKE_RD: begin
				ra      = pos_q[AW-1:0];
				state_d = iol_pkg::S_TAKE_WAIT;
			end
			iol_pkg::S_TAKE_WAIT: begin
				elem_d = rd_q;
				idx_d  = pos_inc;
				if (cmd_q == iol_pkg::CMD_READ) begin
					state_d = iol_pkg::S_DONE;
				end else if (pos_inc >= held_q) begin
					held_d  = CNT_W'(held_q - 1'b1);
					state_d = iol_pkg::S_DONE;
				end else begin
					state_d = iol_pkg::S_SHDN_RD;
				end
			end

			// move entry idx down to idx-1
			iol_pkg::S_SHDN_RD: begin
				ra      = idx_q[AW-1:0];
				state_d = iol_pkg::S_SHDN_WR;
			end
			iol_pkg::S_SHDN_WR: begin
				we    = 1'b1;
				wa    = idx_dec[AW-1:0];
				wd    = rd_q;
				idx_d = idx_inc;
				if (idx_inc == held_q) begin
					held_d  = CNT_W'(held_q - 1'b1);
					state_d = iol_pkg::S_DONE;
				end else begin
					state_d = iol_pkg::S_SHDN_RD;
				end
			end

			iol_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = OUT_PW'({status_q, held_q, found_q, elem_q});
					state_d    = iol_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = iol_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/iol_checker.sv =====
// port-level checks for the indexed ordered list, bound to the top level
module iol_checker #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((iol_pkg::ELEM_W + 1 + $clog2(CAPACITY + 1) + iol_pkg::STAT_W + 7) / 8) * 8 - 1:0]
		m_tdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EW    = iol_pkg::ELEM_W;

	logic [EW-1:0]               o_elem;
	logic                        o_found;
	logic [CNT_W-1:0]            o_count;
	logic [iol_pkg::STAT_W-1:0]  o_status;

	assign o_elem   = m_tdata[EW-1:0];
	assign o_found  = m_tdata[EW];
	assign o_count  = m_tdata[EW + 1 +: CNT_W];
	assign o_status = m_tdata[EW + 1 + CNT_W +: iol_pkg::STAT_W];

	// one command in flight at a time
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (o_status == iol_pkg::ST_FULL) |-> (o_count == CNT_W'(CAPACITY)))
		else $error("full status with list not full");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (o_status != iol_pkg::ST_OK) |-> (o_elem == '0) && !o_found)
		else $error("error result carries data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_count <= CNT_W'(CAPACITY)))
		else $error("count beyond capacity");

endmodule

bind indexed_ordered_list iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
